// File: rtl/hptf_pkg.sv
package hptf_pkg;

  localparam int LEN_W       = 12;
  localparam int CODE_W      = 8;
  localparam int ID_W        = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int MAX_PORTS_DEF = 16;

  localparam logic [LEN_W-1:0] MAX_MESSAGE = LEN_W'(2048);

  localparam logic [CFG_IDX_W-1:0] CFG_CTRL_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HELLO    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_GOODBYE  = CFG_IDX_W'(2);

  localparam logic [LEN_W-1:0]  CTRL_LEN_RST = LEN_W'(1);
  localparam logic [CODE_W-1:0] HELLO_RST    = CODE_W'(1);
  localparam logic [CODE_W-1:0] GOODBYE_RST  = CODE_W'(2);

  typedef enum logic [1:0] {
    OP_NONE,
    OP_HELLO,
    OP_BYE,
    OP_RELAY
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MOVE
  } st_e;

endpackage

// File: rtl/hptf_table.sv
module hptf_table #(
  parameter int MAX_PORTS = hptf_pkg::MAX_PORTS_DEF,
  localparam int IDX_W = $clog2(MAX_PORTS)
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [IDX_W-1:0]      waddr_i,
  input  logic [hptf_pkg::ID_W-1:0] wdata_i,
  input  logic [IDX_W-1:0]      raddr_i,
  output logic [hptf_pkg::ID_W-1:0] rdata_o
);
  import hptf_pkg::*;

  logic [ID_W-1:0] mem [MAX_PORTS];
  logic [ID_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/hptf_ctrl.sv
module hptf_ctrl #(
  parameter int MAX_PORTS = hptf_pkg::MAX_PORTS_DEF,
  localparam int IDX_W = $clog2(MAX_PORTS),
  localparam int CNT_W = $clog2(MAX_PORTS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  hptf_pkg::op_e             op_i,
  input  logic [hptf_pkg::ID_W-1:0] sender_i,
  output logic                      busy_o,
  output logic                      tbl_we_o,
  output logic [IDX_W-1:0]          tbl_waddr_o,
  output logic [hptf_pkg::ID_W-1:0] tbl_wdata_o,
  output logic [IDX_W-1:0]          tbl_raddr_o,
  input  logic [hptf_pkg::ID_W-1:0] tbl_rdata_i,
  output logic                      dest_valid_o,
  output logic [hptf_pkg::ID_W-1:0] dest_id_o,
  output logic                      last_dest_o
);
  import hptf_pkg::*;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(MAX_PORTS);

  st_e              state_q, state_d;
  op_e              op_q, op_d;
  logic [ID_W-1:0]  sender_q, sender_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             rvalid_q, rvalid_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic             pend_q, pend_d;
  logic [ID_W-1:0]  pend_id_q, pend_id_d;
  logic             ov_q, ov_d;
  logic [ID_W-1:0]  od_q, od_d;
  logic             ol_q, ol_d;
  logic             hit;
  logic [CNT_W-1:0] last_idx;

  assign hit      = rvalid_q && (tbl_rdata_i == sender_q);
  assign last_idx = count_q - CNT_W'(1);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sender_d    = sender_q;
    idx_d       = idx_q;
    count_d     = count_q;
    rvalid_d    = 1'b0;
    ridx_d      = idx_q[IDX_W-1:0];
    found_d     = found_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    pend_id_d   = pend_id_q;
    ov_d        = 1'b0;
    od_d        = od_q;
    ol_d        = ol_q;
    tbl_we_o    = 1'b0;
    tbl_waddr_o = count_q[IDX_W-1:0];
    tbl_wdata_o = sender_q;
    tbl_raddr_o = idx_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        if (accept_i && op_i != OP_NONE) begin
          op_d     = op_i;
          sender_d = sender_i;
          idx_d    = '0;
          found_d  = 1'b0;
          pend_d   = 1'b0;
          state_d  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Table entries are unique, so skipping every match skips the sender slot.
        if (rvalid_q) begin
          if (hit && !found_q) begin
            found_d = 1'b1;
            pos_d   = ridx_q;
          end
          if (!hit && op_q == OP_RELAY) begin
            // Hold one beat back so the final destination can be marked.
            if (pend_q) begin
              ov_d = 1'b1;
              od_d = pend_id_q;
              ol_d = 1'b0;
            end
            pend_d    = 1'b1;
            pend_id_d = tbl_rdata_i;
          end
        end
        if (idx_q < count_q) begin
          rvalid_d = 1'b1;
          idx_d    = idx_q + CNT_W'(1);
        end else if (!rvalid_q) begin
          state_d = ST_IDLE;
          case (op_q)
            OP_RELAY: begin
              if (pend_q) begin
                ov_d = 1'b1;
                od_d = pend_id_q;
                ol_d = 1'b1;
              end
            end
            OP_HELLO: begin
              if (!found_q && count_q < FULL) begin
                tbl_we_o = 1'b1;
                count_d  = count_q + CNT_W'(1);
              end
            end
            OP_BYE: begin
              if (found_q) begin
                tbl_raddr_o = last_idx[IDX_W-1:0];
                state_d     = ST_MOVE;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_MOVE: begin
        // Move the last entry into the freed slot.
        tbl_we_o    = 1'b1;
        tbl_waddr_o = pos_q;
        tbl_wdata_o = tbl_rdata_i;
        count_d     = last_idx;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rvalid_q <= 1'b0;
      pend_q   <= 1'b0;
      found_q  <= 1'b0;
      ov_q     <= 1'b0;
      op_q     <= OP_NONE;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
      pend_q   <= pend_d;
      found_q  <= found_d;
      ov_q     <= ov_d;
      op_q     <= op_d;
      idx_q    <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sender_q  <= sender_d;
    ridx_q    <= ridx_d;
    pos_q     <= pos_d;
    pend_id_q <= pend_id_d;
    od_q      <= od_d;
    ol_q      <= ol_d;
  end

  assign busy_o       = (state_q != ST_IDLE);
  assign dest_valid_o = ov_q;
  assign dest_id_o    = od_q;
  assign last_dest_o  = ol_q;

endmodule

// File: rtl/hub_port_table_flood_top.sv
// Repeater hub port table with flood-except-sender relay.
// Input: pulse start with msg_length_i, first_byte_i and sender_id_i while
// busy is low; the message is taken at that edge. A message whose clamped
// length equals the control length emits nothing; a hello or goodbye code
// edits the port table, any other code is ignored; other messages are relayed.
// Output: one beat per destination on dest_id_o / last_dest_o, marked by
// dest_valid_o for one cycle, in table order, sender skipped, last_dest_o set
// on the final beat. The receiver cannot stall the block.
// Timing: each item walks the table through one read port and one comparator,
// one entry per cycle. Busy stays high from acceptance until the walk ends, and
// through ST_MOVE for a goodbye that finds its sender; an unknown control code
// never raises busy. Relay beats come one per cycle, with a gap where the sender
// is skipped, the last in the first cycle with busy low.
// Configuration: cfg_we_i writes register cfg_idx_i (0 control length,
// 1 hello code, 2 goodbye code) at once; write only while idle.
// Reset: the port table is emptied (count cleared) and the registers return
// to 1, 1 and 2. Table memory needs no clearing pass.
module hub_port_table_flood_top #(
  parameter int MAX_PORTS = hptf_pkg::MAX_PORTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [hptf_pkg::LEN_W-1:0]      msg_length_i,
  input  logic [hptf_pkg::CODE_W-1:0]     first_byte_i,
  input  logic [hptf_pkg::ID_W-1:0]       sender_id_i,
  input  logic                            cfg_we_i,
  input  logic [hptf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hptf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic                            dest_valid_o,
  output logic [hptf_pkg::ID_W-1:0]       dest_id_o,
  output logic                            last_dest_o
);
  import hptf_pkg::*;

  localparam int IDX_W = $clog2(MAX_PORTS);

  logic [LEN_W-1:0]  ctrl_len_q;
  logic [CODE_W-1:0] hello_q;
  logic [CODE_W-1:0] bye_q;
  logic [LEN_W-1:0]  len_clamp;
  logic              accept;
  op_e               op;

  logic              tbl_we;
  logic [IDX_W-1:0]  tbl_waddr;
  logic [ID_W-1:0]   tbl_wdata;
  logic [IDX_W-1:0]  tbl_raddr;
  logic [ID_W-1:0]   tbl_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_len_q <= CTRL_LEN_RST;
      hello_q    <= HELLO_RST;
      bye_q      <= GOODBYE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CTRL_LEN: ctrl_len_q <= cfg_data_i[LEN_W-1:0];
        CFG_HELLO:    hello_q    <= cfg_data_i[CODE_W-1:0];
        CFG_GOODBYE:  bye_q      <= cfg_data_i[CODE_W-1:0];
        default: begin
          ctrl_len_q <= ctrl_len_q;
        end
      endcase
    end
  end

  assign accept    = start && !busy;
  // Clamp over-long messages to the receive buffer size.
  assign len_clamp = (msg_length_i > MAX_MESSAGE) ? MAX_MESSAGE : msg_length_i;

  always_comb begin
    if (len_clamp != ctrl_len_q) begin
      op = OP_RELAY;
    end else if (first_byte_i == hello_q) begin
      op = OP_HELLO;
    end else if (first_byte_i == bye_q) begin
      op = OP_BYE;
    end else begin
      op = OP_NONE;
    end
  end

  hptf_table #(
    .MAX_PORTS(MAX_PORTS)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (tbl_we),
    .waddr_i(tbl_waddr),
    .wdata_i(tbl_wdata),
    .raddr_i(tbl_raddr),
    .rdata_o(tbl_rdata)
  );

  hptf_ctrl #(
    .MAX_PORTS(MAX_PORTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (op),
    .sender_i    (sender_id_i),
    .busy_o      (busy),
    .tbl_we_o    (tbl_we),
    .tbl_waddr_o (tbl_waddr),
    .tbl_wdata_o (tbl_wdata),
    .tbl_raddr_o (tbl_raddr),
    .tbl_rdata_i (tbl_rdata),
    .dest_valid_o(dest_valid_o),
    .dest_id_o   (dest_id_o),
    .last_dest_o (last_dest_o)
  );

endmodule

// File: verif/hptf_checker.sv
module hptf_checker #(
  parameter int MAX_PORTS = hptf_pkg::MAX_PORTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic [hptf_pkg::LEN_W-1:0]      msg_length_i,
  input  logic [hptf_pkg::CODE_W-1:0]     first_byte_i,
  input  logic [hptf_pkg::ID_W-1:0]       sender_id_i,
  input  logic                            cfg_we_i,
  input  logic [hptf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hptf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            dest_valid_o,
  input  logic [hptf_pkg::ID_W-1:0]       dest_id_o,
  input  logic                            last_dest_o,
  output int                              errors_o,
  output int                              pending_o,
  output int                              beats_o
);
  import hptf_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            last;
  } dest_beat_t;

  dest_beat_t       dest_q[$];
  dest_beat_t       want;
  logic [ID_W-1:0]  ports [MAX_PORTS];
  int               n_ports;
  logic [LEN_W-1:0] ctrl_len;
  logic [CODE_W-1:0] hello_code;
  logic [CODE_W-1:0] bye_code;
  int               errors;
  int               beats;

  // Position of id among the joined ports, n_ports when absent.
  function automatic int member_slot(input logic [ID_W-1:0] id);
    for (int i = 0; i < n_ports; i++) begin
      if (ports[i] == id) return i;
    end
    return n_ports;
  endfunction

  function automatic op_e classify(input logic [LEN_W-1:0] len,
                                   input logic [CODE_W-1:0] code);
    logic [LEN_W-1:0] eff;
    eff = (len > MAX_MESSAGE) ? MAX_MESSAGE : len;
    if (eff != ctrl_len) return OP_RELAY;
    if (code == hello_code) return OP_HELLO;
    if (code == bye_code) return OP_BYE;
    return OP_NONE;
  endfunction

  // Edit the port table or queue the flood destinations for one message.
  task automatic take_message(input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                              input logic [ID_W-1:0] id);
    int pos;
    int last_i;
    pos = member_slot(id);
    case (classify(len, code))
      OP_HELLO: begin
        if (n_ports < MAX_PORTS && pos == n_ports) begin
          ports[n_ports] = id;
          n_ports++;
        end
      end
      OP_BYE: begin
        // fill the hole with the last entry
        if (pos < n_ports) begin
          ports[pos] = ports[n_ports-1];
          n_ports--;
        end
      end
      OP_RELAY: begin
        last_i = -1;
        for (int i = 0; i < n_ports; i++) begin
          if (i != pos) last_i = i;
        end
        for (int i = 0; i < n_ports; i++) begin
          if (i != pos) dest_q.push_back('{id: ports[i], last: (i == last_i)});
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_q.delete();
      n_ports    = 0;
      ctrl_len   = CTRL_LEN_RST;
      hello_code = HELLO_RST;
      bye_code   = GOODBYE_RST;
      errors     = 0;
      beats      = 0;
      pending_o <= 0;
      errors_o  <= 0;
      beats_o   <= 0;
    end else begin
      if (dest_valid_o) begin
        beats++;
        if (dest_q.size() == 0) begin
          $error("dest_id: unexpected beat, expected none, got 0x%04h", dest_id_o);
          errors++;
        end else begin
          want = dest_q.pop_front();
          if (dest_id_o !== want.id) begin
            $error("dest_id mismatch: expected 0x%04h, got 0x%04h", want.id, dest_id_o);
            errors++;
          end
          if (last_dest_o !== want.last) begin
            $error("last_dest mismatch: expected %0b, got %0b", want.last, last_dest_o);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CTRL_LEN: ctrl_len   = cfg_data_i[LEN_W-1:0];
          CFG_HELLO:    hello_code = cfg_data_i[CODE_W-1:0];
          CFG_GOODBYE:  bye_code   = cfg_data_i[CODE_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) take_message(msg_length_i, first_byte_i, sender_id_i);
      pending_o <= dest_q.size();
      errors_o  <= errors;
      beats_o   <= beats;
    end
  end

endmodule

// File: verif/testbench.sv
module testbench;
  import hptf_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE      = 24;
  localparam int POOL_N      = 24;
  localparam int PHASE_ITEMS = 76;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  start        = 1'b0;
  logic                  busy;
  logic [LEN_W-1:0]      msg_length_i = '0;
  logic [CODE_W-1:0]     first_byte_i = '0;
  logic [ID_W-1:0]       sender_id_i  = '0;
  logic                  cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i    = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;
  logic                  dest_valid_o;
  logic [ID_W-1:0]       dest_id_o;
  logic                  last_dest_o;

  int fails;
  int pending;
  int beats;
  int stall_cycles = 0;
  int msgs_sent    = 0;
  int settings     = 1;
  bit gaps_on      = 1'b1;

  logic [LEN_W-1:0]  cur_ctrl  = CTRL_LEN_RST;
  logic [CODE_W-1:0] cur_hello = HELLO_RST;
  logic [CODE_W-1:0] cur_bye   = GOODBYE_RST;
  logic [ID_W-1:0]   pool [POOL_N];

  hub_port_table_flood_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .msg_length_i (msg_length_i),
    .first_byte_i (first_byte_i),
    .sender_id_i  (sender_id_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .dest_valid_o (dest_valid_o),
    .dest_id_o    (dest_id_o),
    .last_dest_o  (last_dest_o)
  );

  hptf_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .msg_length_i (msg_length_i),
    .first_byte_i (first_byte_i),
    .sender_id_i  (sender_id_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .dest_valid_o (dest_valid_o),
    .dest_id_o    (dest_id_o),
    .last_dest_o  (last_dest_o),
    .errors_o     (fails),
    .pending_o    (pending),
    .beats_o      (beats)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if ((start && !busy) || dest_valid_o || cfg_we_i) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hold start high until the message is taken; start stays high on return.
  task automatic send(input logic [LEN_W-1:0] len, input logic [CODE_W-1:0] code,
                      input logic [ID_W-1:0] id);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
    start        <= 1'b1;
    msg_length_i <= len;
    first_byte_i <= code;
    sender_id_i  <= id;
    do @(posedge clk_i); while (busy);
    msgs_sent++;
  endtask

  // Drain outstanding destinations, then let the block finish any table edit.
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [LEN_W-1:0] ctrl, input logic [CODE_W-1:0] hello,
                              input logic [CODE_W-1:0] bye, input bit poke_unused);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_CTRL_LEN;
    cfg_data_i <= CFG_DATA_W'(ctrl);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HELLO;
    cfg_data_i <= {4'($urandom_range(0, 15)), hello};
    @(posedge clk_i);
    cfg_idx_i  <= CFG_GOODBYE;
    cfg_data_i <= {4'($urandom_range(0, 15)), bye};
    @(posedge clk_i);
    if (poke_unused) begin
      cfg_idx_i  <= CFG_UNUSED;
      cfg_data_i <= CFG_DATA_W'($urandom_range(0, 4095));
      @(posedge clk_i);
    end
    cfg_we_i  <= 1'b0;
    cur_ctrl  = ctrl;
    cur_hello = hello;
    cur_bye   = bye;
    settings++;
    @(posedge clk_i);
  endtask

  // Mostly joins, leaves and floods from a small id pool, plus some noise.
  task automatic random_phase(input int n_items);
    int                pick;
    op_e               kind;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
    logic [ID_W-1:0]   id;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) kind = OP_HELLO;
      else if (pick < 65) kind = OP_BYE;
      else if (pick < 95) kind = OP_RELAY;
      else kind = OP_NONE;
      id = pool[$urandom_range(0, POOL_N-1)];
      if (cur_ctrl == MAX_MESSAGE && $urandom_range(0, 1) == 1) begin
        len = LEN_W'($urandom_range(2049, 4095));
      end else begin
        len = cur_ctrl;
      end
      case (kind)
        OP_HELLO: code = cur_hello;
        OP_BYE:   code = cur_bye;
        OP_RELAY: begin
          do len = LEN_W'($urandom_range(0, 4095));
          while (((len > MAX_MESSAGE) ? MAX_MESSAGE : len) == cur_ctrl);
          code = CODE_W'($urandom_range(0, 255));
          if ($urandom_range(0, 4) == 0) id = ID_W'($urandom_range(0, 65535));
        end
        default: begin
          code = CODE_W'($urandom_range(0, 255));
          id   = ID_W'($urandom_range(0, 65535));
        end
      endcase
      send(len, code, id);
    end
  endtask

  initial begin
    logic [CODE_W-1:0] same_code;
    pool[0] = '0;
    pool[1] = '1;
    for (int k = 2; k < 17; k++) pool[k] = ID_W'(16'h0100 + k - 2);
    for (int k = 17; k < POOL_N; k++) pool[k] = ID_W'($urandom_range(0, 65535));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: defaults are control length 1, hello 1, goodbye 2.
    send(12'd0, 8'h00, 16'h1234);     // flood into an empty table
    send(12'd1, 8'h01, 16'h0000);
    send(12'd1, 8'h01, 16'hFFFF);
    send(12'd1, 8'h01, 16'hFFFF);     // duplicate join
    send(12'hFFF, 8'hFF, 16'hFFFF);   // over-long, clamps to max length
    send(12'd1, 8'h7F, 16'h0000);     // unknown control code
    send(12'd1, 8'h02, 16'h5555);     // leave from a stranger
    send(12'd1, 8'h02, 16'h0000);
    send(12'd2048, 8'h01, 16'hFFFF);  // sole member floods to nobody
    for (int k = 2; k < 17; k++) send(12'd1, 8'h01, pool[k]);
    send(12'd1, 8'h01, 16'h0200);     // table full
    send(12'd2, 8'h01, pool[7]);      // member floods, skips itself
    send(12'd100, 8'hA5, 16'hBEEF);   // outsider floods to every entry
    settle();

    program_regs(MAX_MESSAGE, 8'h00, 8'hFF, 1'b1);
    random_phase(PHASE_ITEMS);
    settle();

    program_regs(12'd1, 8'hFF, 8'h00, 1'b0);
    random_phase(PHASE_ITEMS);
    settle();

    // hello and goodbye share a code: every such message is a join
    same_code = CODE_W'($urandom_range(0, 255));
    program_regs(LEN_W'($urandom_range(1, 2048)), same_code, same_code, 1'b1);
    random_phase(PHASE_ITEMS);
    settle();

    gaps_on = 1'b0;
    program_regs(LEN_W'($urandom_range(1, 2048)), CODE_W'($urandom_range(0, 255)),
                 CODE_W'($urandom_range(0, 255)), 1'b0);
    random_phase(PHASE_ITEMS);
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (32) @(posedge clk_i);

    $display("Ran %0d messages under %0d register settings; %0d flood beats compared.",
             msgs_sent, settings, beats);
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hptf_pkg.sv
rtl/hptf_table.sv
rtl/hptf_ctrl.sv
rtl/hub_port_table_flood_top.sv
verif/hptf_checker.sv
verif/testbench.sv
